/* rtl/ecp_pkg.sv */
// Package for the event counter pool: operation and status codes, fixed field widths,
// and the count limit. Used by the top level and the counter RAM. No dependencies.
package ecp_pkg;

    // Fixed widths of the command and result fields.
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 10;
    localparam int INIT_W   = 32;
    localparam int CNT_W    = 64;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 3;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADHANDLE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_AGAIN     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd5;

    // Largest count a counter may hold, and the shortest valid transfer length.
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 64'hffff_ffff_ffff_fffe;
    localparam logic [LEN_W-1:0] MIN_LENGTH  = 16'd8;

    // One entry of the counter memory.
    typedef struct packed {
        logic             semaphore;
        logic             nonblocking;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

/* rtl/event_counter_pool.sv */
// Event counter pool top level: command capture, execute step and result word.
// The result word appears on done from registers loaded in the execute step, after the RAM read.
// No new command is taken while one executes, as the counter RAM is read and then written.
// The receiver cannot stall; busy is high only in the execute cycle after the RAM read.
// Reset frees all slots at once through the in-use bits; the RAM needs no clearing pass.
// Depends on ecp_pkg, ecp_counter_ram and ecp_slot_alloc.
module event_counter_pool #(
    parameter int SLOTS       = 64,
    parameter int HANDLE_BASE = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ecp_pkg::OP_W-1:0]        operation,
    input  logic [ecp_pkg::HANDLE_W-1:0]    handle,
    input  logic [ecp_pkg::INIT_W-1:0]      init_value,
    input  logic                            semaphore_mode,
    input  logic                            nonblocking,
    input  logic [ecp_pkg::CNT_W-1:0]       add_value,
    input  logic [ecp_pkg::LEN_W-1:0]       request_length,
    input  logic                            buffer_present,
    output logic                            done,
    output logic [ecp_pkg::STATUS_W-1:0]    status,
    output logic [ecp_pkg::HANDLE_W-1:0]    new_handle,
    output logic [ecp_pkg::CNT_W-1:0]       read_value,
    output logic                            readable,
    output logic                            writable
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DIFF_W = ecp_pkg::HANDLE_W + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // Captured command word.
    logic [ecp_pkg::OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       in_range_reg;
    logic [ecp_pkg::INIT_W-1:0] init_reg;
    logic                       sem_reg;
    logic                       nb_reg;
    logic [ecp_pkg::CNT_W-1:0]  add_reg;
    logic                       xfer_ok_reg;

    // Handle decode.
    logic [DIFF_W-1:0] handle_diff;
    logic              handle_in_range;

    // RAM and allocator links.
    ecp_pkg::entry_t   rd_entry;
    ecp_pkg::entry_t   wr_entry;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              upd_en;
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_val;
    logic              chk_in_use;
    logic [SLOT_W-1:0] free_slot;
    logic              pool_full;

    // Execute results.
    logic                          valid_slot;
    logic [ecp_pkg::CNT_W:0]       sum;
    logic                          stall;
    logic [ecp_pkg::STATUS_W-1:0]  status_next;
    logic [ecp_pkg::HANDLE_W-1:0]  new_handle_next;
    logic [ecp_pkg::CNT_W-1:0]     read_value_next;
    logic                          readable_next;
    logic                          writable_next;

    logic                          done_reg;
    logic [ecp_pkg::STATUS_W-1:0]  status_reg;
    logic [ecp_pkg::HANDLE_W-1:0]  new_handle_reg;
    logic [ecp_pkg::CNT_W-1:0]     read_value_reg;
    logic                          readable_reg;
    logic                          writable_reg;

    assign busy   = (state_reg == ST_EXEC);
    assign accept = start && !busy;

    // Map the handle onto a slot number.
    assign handle_diff     = {1'b0, handle} - DIFF_W'(HANDLE_BASE);
    assign handle_in_range = ({1'b0, handle} >= DIFF_W'(HANDLE_BASE))
                             && (handle_diff < DIFF_W'(SLOTS));

    // Sequencer: the RAM read on accept, then execute and write back.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= operation;
            slot_reg     <= handle_diff[SLOT_W-1:0];
            in_range_reg <= handle_in_range;
            init_reg     <= init_value;
            sem_reg      <= semaphore_mode;
            nb_reg       <= nonblocking;
            add_reg      <= add_value;
            xfer_ok_reg  <= (request_length >= ecp_pkg::MIN_LENGTH) && buffer_present;
        end
    end

    ecp_counter_ram #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (handle_diff[SLOT_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    ecp_slot_alloc #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd_en     (upd_en),
        .upd_slot   (upd_slot),
        .upd_val    (upd_val),
        .chk_slot   (slot_reg),
        .chk_in_use (chk_in_use),
        .free_slot  (free_slot),
        .full       (pool_full)
    );

    assign valid_slot = in_range_reg && chk_in_use;

    // A write overflows when count plus amount passes the limit.
    assign sum   = {1'b0, rd_entry.count} + {1'b0, add_reg};
    assign stall = (sum > {1'b0, ecp_pkg::COUNT_LIMIT});

    // Execute step: decide the result and the write-back.
    always_comb
    begin
        status_next     = ecp_pkg::ST_OK;
        new_handle_next = '0;
        read_value_next = '0;
        readable_next   = 1'b0;
        writable_next   = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_entry        = rd_entry;
        upd_en          = 1'b0;
        upd_slot        = slot_reg;
        upd_val         = 1'b0;
        case (op_reg)
            ecp_pkg::OP_CREATE:
            begin
                if (pool_full)
                begin
                    status_next = ecp_pkg::ST_FULL;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_addr              = free_slot;
                    wr_entry.count       = {{(ecp_pkg::CNT_W - ecp_pkg::INIT_W){1'b0}}, init_reg};
                    wr_entry.semaphore   = sem_reg;
                    wr_entry.nonblocking = nb_reg;
                    upd_en               = 1'b1;
                    upd_slot             = free_slot;
                    upd_val              = 1'b1;
                    new_handle_next      = ecp_pkg::HANDLE_W'(HANDLE_BASE)
                                           + ecp_pkg::HANDLE_W'(free_slot);
                end
            end
            ecp_pkg::OP_CLOSE:
            begin
                if (!valid_slot)
                begin
                    status_next = ecp_pkg::ST_BADHANDLE;
                end
                else
                begin
                    upd_en  = 1'b1;
                    upd_val = 1'b0;
                end
            end
            ecp_pkg::OP_READ:
            begin
                if (!valid_slot || !xfer_ok_reg)
                begin
                    status_next = ecp_pkg::ST_INVALID;
                end
                else if (rd_entry.count == '0)
                begin
                    status_next = rd_entry.nonblocking ? ecp_pkg::ST_AGAIN : ecp_pkg::ST_WAIT;
                end
                else if (rd_entry.semaphore)
                begin
                    read_value_next = ecp_pkg::CNT_W'(1);
                    wr_en           = 1'b1;
                    wr_entry.count  = rd_entry.count - ecp_pkg::CNT_W'(1);
                end
                else
                begin
                    read_value_next = rd_entry.count;
                    wr_en           = 1'b1;
                    wr_entry.count  = '0;
                end
            end
            ecp_pkg::OP_WRITE:
            begin
                if (!valid_slot || !xfer_ok_reg)
                begin
                    status_next = ecp_pkg::ST_INVALID;
                end
                else if (stall)
                begin
                    status_next = rd_entry.nonblocking ? ecp_pkg::ST_AGAIN : ecp_pkg::ST_WAIT;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_entry.count = sum[ecp_pkg::CNT_W-1:0];
                end
            end
            ecp_pkg::OP_STATUS:
            begin
                if (valid_slot)
                begin
                    readable_next = (rd_entry.count != '0);
                    writable_next = (rd_entry.count < ecp_pkg::COUNT_LIMIT);
                end
            end
            default:
            begin
                status_next = ecp_pkg::ST_INVALID;
            end
        endcase
        if (state_reg != ST_EXEC)
        begin
            wr_en  = 1'b0;
            upd_en = 1'b0;
        end
    end

    // Result word, shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            status_reg     <= status_next;
            new_handle_reg <= new_handle_next;
            read_value_reg <= read_value_next;
            readable_reg   <= readable_next;
            writable_reg   <= writable_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign new_handle = new_handle_reg;
    assign read_value = read_value_reg;
    assign readable   = readable_reg;
    assign writable   = writable_reg;

endmodule

/* rtl/ecp_counter_ram.sv */
// Synchronous single-port-write, single-port-read memory that holds the counter
// and mode marks of every slot. Depends on ecp_pkg for the entry type.
module ecp_counter_ram #(
    parameter int SLOTS  = 64,
    parameter int SLOT_W = 6
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [SLOT_W-1:0]   rd_addr,
    output ecp_pkg::entry_t     rd_data,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_addr,
    input  ecp_pkg::entry_t     wr_data
);

    ecp_pkg::entry_t mem [SLOTS];
    ecp_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ecp_slot_alloc.sv */
// In-use bits of all slots and the registered search for the lowest free slot.
// Depends on no package items.
module ecp_slot_alloc #(
    parameter int SLOTS  = 64,
    parameter int SLOT_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd_en,
    input  logic [SLOT_W-1:0] upd_slot,
    input  logic              upd_val,
    input  logic [SLOT_W-1:0] chk_slot,
    output logic              chk_in_use,
    output logic [SLOT_W-1:0] free_slot,
    output logic              full
);

    logic [SLOTS-1:0]  in_use_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic [SLOT_W-1:0] free_slot_next;
    logic              full_reg;
    logic              full_next;

    // Set or clear one in-use bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else if (upd_en)
        begin
            in_use_reg[upd_slot] <= upd_val;
        end
    end

    // Lowest free slot, found from the current bits and registered.
    always_comb
    begin
        free_slot_next = '0;
        full_next      = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot_next = SLOT_W'(i);
                full_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_slot_reg <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            free_slot_reg <= free_slot_next;
            full_reg      <= full_next;
        end
    end

    assign chk_in_use = in_use_reg[chk_slot];
    assign free_slot  = free_slot_reg;
    assign full       = full_reg;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for event_counter_pool: a queue-fed driver issues command words,
// a local model of the slot pool predicts each result word, and a monitor compares them.
// Depends on ecp_pkg and event_counter_pool.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 64;
    localparam int HANDLE_BASE  = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int REPLY_WAIT   = 100;
    localparam int PRINT_LIMIT  = 50;

    // One command word as queued for the driver, with its idle chance.
    typedef struct packed {
        bit                           drain;
        bit [6:0]                     idle_pct;
        logic [ecp_pkg::OP_W-1:0]     op;
        logic [ecp_pkg::HANDLE_W-1:0] hnd;
        logic [ecp_pkg::INIT_W-1:0]   init;
        logic                         sem;
        logic                         nb;
        logic [ecp_pkg::CNT_W-1:0]    add;
        logic [ecp_pkg::LEN_W-1:0]    len;
        logic                         has_buffer;
    } command_t;

    // One result word.
    typedef struct packed {
        logic [ecp_pkg::STATUS_W-1:0] status;
        logic [ecp_pkg::HANDLE_W-1:0] new_handle;
        logic [ecp_pkg::CNT_W-1:0]    read_value;
        logic                         readable;
        logic                         writable;
    } reply_t;

    typedef enum {MIX_OPS, FILL_POOL, EMPTY_POOL} traffic_t;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         start          = 1'b0;
    logic                         busy;
    logic [ecp_pkg::OP_W-1:0]     operation      = ecp_pkg::OP_CREATE;
    logic [ecp_pkg::HANDLE_W-1:0] handle         = '0;
    logic [ecp_pkg::INIT_W-1:0]   init_value     = '0;
    logic                         semaphore_mode = 1'b0;
    logic                         nonblocking    = 1'b0;
    logic [ecp_pkg::CNT_W-1:0]    add_value      = '0;
    logic [ecp_pkg::LEN_W-1:0]    request_length = '0;
    logic                         buffer_present = 1'b0;
    logic                         done;
    logic [ecp_pkg::STATUS_W-1:0] status;
    logic [ecp_pkg::HANDLE_W-1:0] new_handle;
    logic [ecp_pkg::CNT_W-1:0]    read_value;
    logic                         readable;
    logic                         writable;

    // Local copy of the pool state.
    bit                           slot_live  [SLOTS];
    logic [ecp_pkg::CNT_W-1:0]    slot_count [SLOTS];
    bit                           slot_sem   [SLOTS];
    bit                           slot_nb    [SLOTS];

    command_t command_queue[$];
    reply_t   expected_replies[$];
    command_t on_bus;
    bit       word_taken  = 1'b0;
    int       error_count = 0;
    int       cycle_count = 0;

    event_counter_pool #(
        .SLOTS       (SLOTS),
        .HANDLE_BASE (HANDLE_BASE)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .handle         (handle),
        .init_value     (init_value),
        .semaphore_mode (semaphore_mode),
        .nonblocking    (nonblocking),
        .add_value      (add_value),
        .request_length (request_length),
        .buffer_present (buffer_present),
        .done           (done),
        .status         (status),
        .new_handle     (new_handle),
        .read_value     (read_value),
        .readable       (readable),
        .writable       (writable)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slot index of a live handle, or -1.
    function automatic int slot_of(input logic [ecp_pkg::HANDLE_W-1:0] h);
        int idx;
        idx = int'(h) - HANDLE_BASE;
        if (idx < 0 || idx >= SLOTS)
            return -1;
        if (!slot_live[idx])
            return -1;
        return idx;
    endfunction

    // Apply one accepted command to the local pool and queue its result word.
    task automatic execute_command(input command_t c);
        reply_t r;
        int     s;
        int     i;
        r = '0;
        s = slot_of(c.hnd);
        case (c.op)
            ecp_pkg::OP_CREATE:
            begin
                s = -1;
                for (i = SLOTS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        s = i;
                if (s < 0)
                    r.status = ecp_pkg::ST_FULL;
                else
                begin
                    slot_live[s]  = 1'b1;
                    slot_count[s] = {32'h0, c.init};
                    slot_sem[s]   = c.sem;
                    slot_nb[s]    = c.nb;
                    r.new_handle  = ecp_pkg::HANDLE_W'(HANDLE_BASE + s);
                end
            end
            ecp_pkg::OP_CLOSE:
            begin
                if (s < 0)
                    r.status = ecp_pkg::ST_BADHANDLE;
                else
                begin
                    slot_live[s]  = 1'b0;
                    slot_count[s] = '0;
                    slot_sem[s]   = 1'b0;
                    slot_nb[s]    = 1'b0;
                end
            end
            ecp_pkg::OP_READ:
            begin
                if (s < 0 || c.len < ecp_pkg::MIN_LENGTH || !c.has_buffer)
                    r.status = ecp_pkg::ST_INVALID;
                else if (slot_count[s] == '0)
                    r.status = slot_nb[s] ? ecp_pkg::ST_AGAIN : ecp_pkg::ST_WAIT;
                else if (slot_sem[s])
                begin
                    r.read_value  = 64'd1;
                    slot_count[s] = slot_count[s] - 64'd1;
                end
                else
                begin
                    r.read_value  = slot_count[s];
                    slot_count[s] = '0;
                end
            end
            ecp_pkg::OP_WRITE:
            begin
                if (s < 0 || c.len < ecp_pkg::MIN_LENGTH || !c.has_buffer)
                    r.status = ecp_pkg::ST_INVALID;
                else if (slot_count[s] > ecp_pkg::COUNT_LIMIT
                         || ecp_pkg::COUNT_LIMIT - slot_count[s] < c.add)
                    r.status = slot_nb[s] ? ecp_pkg::ST_AGAIN : ecp_pkg::ST_WAIT;
                else
                    slot_count[s] = slot_count[s] + c.add;
            end
            ecp_pkg::OP_STATUS:
            begin
                if (s >= 0)
                begin
                    r.readable = (slot_count[s] != '0);
                    r.writable = (slot_count[s] < ecp_pkg::COUNT_LIMIT);
                end
            end
            default:
                r.status = ecp_pkg::ST_INVALID;
        endcase
        expected_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [ecp_pkg::CNT_W-1:0] got,
                                   input logic [ecp_pkg::CNT_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    task automatic queue_command(input logic [ecp_pkg::OP_W-1:0] op, input int hnd,
                                 input logic [ecp_pkg::INIT_W-1:0] init, input logic sem,
                                 input logic nb, input logic [ecp_pkg::CNT_W-1:0] add,
                                 input logic [ecp_pkg::LEN_W-1:0] len,
                                 input logic has_buffer);
        command_t c;
        c            = '0;
        c.op         = op;
        c.hnd        = ecp_pkg::HANDLE_W'(hnd);
        c.init       = init;
        c.sem        = sem;
        c.nb         = nb;
        c.add        = add;
        c.len        = len;
        c.has_buffer = has_buffer;
        command_queue.push_back(c);
    endtask

    // Random command word; handles lean toward the low slots, where live counters sit.
    function automatic command_t random_command(input traffic_t mix, input int idle_pct);
        command_t c;
        int       r;
        c          = '0;
        c.idle_pct = 7'(idle_pct);
        c.sem      = 1'($urandom_range(0, 1));
        c.nb       = 1'($urandom_range(0, 1));
        c.init     = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20);

        r = $urandom_range(0, 99);
        if (r < 15)
            c.hnd = ecp_pkg::HANDLE_W'($urandom_range(0, (1 << ecp_pkg::HANDLE_W) - 1));
        else if (r < 20)
            c.hnd = ecp_pkg::HANDLE_W'($urandom_range(0, 1) ? HANDLE_BASE - 1
                                                             : HANDLE_BASE + SLOTS);
        else if (r < 60)
            c.hnd = ecp_pkg::HANDLE_W'(HANDLE_BASE + $urandom_range(0, 7));
        else
            c.hnd = ecp_pkg::HANDLE_W'(HANDLE_BASE + $urandom_range(0, SLOTS - 1));

        r = $urandom_range(0, 99);
        if (r < 35)
            c.add = ecp_pkg::CNT_W'($urandom_range(0, 20));
        else if (r < 55)
            c.add = {$urandom, $urandom};
        else if (r < 75)
            c.add = ecp_pkg::COUNT_LIMIT - ecp_pkg::CNT_W'($urandom_range(0, 20));
        else if (r < 85)
            c.add = {32'h0, $urandom};
        else if (r < 92)
            c.add = '1;
        else
            c.add = ecp_pkg::COUNT_LIMIT;

        r = $urandom_range(0, 99);
        if (r < 8)
            c.len = ecp_pkg::LEN_W'($urandom_range(0, int'(ecp_pkg::MIN_LENGTH) - 1));
        else if (r < 20)
            c.len = ecp_pkg::MIN_LENGTH;
        else if (r < 45)
            c.len = ecp_pkg::LEN_W'($urandom_range(0, (1 << ecp_pkg::LEN_W) - 1));
        else
            c.len = ecp_pkg::LEN_W'($urandom_range(int'(ecp_pkg::MIN_LENGTH), 64));
        c.has_buffer = ($urandom_range(0, 99) >= 6);

        r = $urandom_range(0, 99);
        case (mix)
            FILL_POOL:
                c.op = (r < 75) ? ecp_pkg::OP_CREATE
                     : (r < 90) ? ecp_pkg::OP_WRITE : ecp_pkg::OP_STATUS;
            EMPTY_POOL:
                c.op = (r < 75) ? ecp_pkg::OP_CLOSE
                     : (r < 90) ? ecp_pkg::OP_READ : ecp_pkg::OP_STATUS;
            default:
            begin
                if (r < 18)
                    c.op = ecp_pkg::OP_CREATE;
                else if (r < 28)
                    c.op = ecp_pkg::OP_CLOSE;
                else if (r < 52)
                    c.op = ecp_pkg::OP_READ;
                else if (r < 78)
                    c.op = ecp_pkg::OP_WRITE;
                else if (r < 95)
                    c.op = ecp_pkg::OP_STATUS;
                else
                    c.op = ecp_pkg::OP_W'($urandom_range(int'(ecp_pkg::OP_STATUS) + 1,
                                                         (1 << ecp_pkg::OP_W) - 1));
            end
        endcase
        return c;
    endfunction

    // Driver: a word stays on the bus until taken, then the next one or an idle cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            if (command_queue.size() == 0)
                start <= 1'b0;
            else if (command_queue[0].drain)
            begin
                start <= 1'b0;
                if (expected_replies.size() == 0)
                    command_queue.delete(0);
            end
            else if ($urandom_range(0, 99) < command_queue[0].idle_pct)
                start <= 1'b0;
            else
            begin
                on_bus = command_queue.pop_front();
                start          <= 1'b1;
                operation      <= on_bus.op;
                handle         <= on_bus.hnd;
                init_value     <= on_bus.init;
                semaphore_mode <= on_bus.sem;
                nonblocking    <= on_bus.nb;
                add_value      <= on_bus.add;
                request_length <= on_bus.len;
                buffer_present <= on_bus.has_buffer;
            end
        end
    end

    // Monitor: check the result word against the oldest prediction, then predict the word
    // taken at this edge.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("result word with nothing expected",
                                ecp_pkg::CNT_W'(status), '0);
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                    report_mismatch("status", ecp_pkg::CNT_W'(status),
                                    ecp_pkg::CNT_W'(want.status));
                if (new_handle !== want.new_handle)
                    report_mismatch("new_handle", ecp_pkg::CNT_W'(new_handle),
                                    ecp_pkg::CNT_W'(want.new_handle));
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (readable !== want.readable)
                    report_mismatch("readable", ecp_pkg::CNT_W'(readable),
                                    ecp_pkg::CNT_W'(want.readable));
                if (writable !== want.writable)
                    report_mismatch("writable", ecp_pkg::CNT_W'(writable),
                                    ecp_pkg::CNT_W'(want.writable));
            end
        end
        word_taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            execute_command(on_bus);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        command_t pause_word;
        int       phase;
        int       idle;
        int       k;
        int       n;

        pause_word       = '0;
        pause_word.drain = 1'b1;

        // Directed words: invalid handles, empty and full counters, bad lengths,
        // semaphore reads, unknown operations, reuse of a closed slot.
        queue_command(ecp_pkg::OP_STATUS, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_CLOSE, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_CREATE, 0, '0, 1'b0, 1'b1, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_WRITE, HANDLE_BASE, '0, 1'b0, 1'b0, ecp_pkg::COUNT_LIMIT,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_STATUS, HANDLE_BASE, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_WRITE, HANDLE_BASE, '0, 1'b0, 1'b0, 64'd1,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_WRITE, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH - 16'd1, 1'b1);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b0);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE, '0, 1'b0, 1'b0, '0, '1, 1'b1);
        queue_command(ecp_pkg::OP_CREATE, 0, '1, 1'b1, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_WRITE, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '1,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_STATUS, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_WRITE, HANDLE_BASE - 1, '0, 1'b0, 1'b0, 64'd1,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_STATUS, HANDLE_BASE + SLOTS, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_READ, (1 << ecp_pkg::HANDLE_W) - 1, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        for (k = int'(ecp_pkg::OP_STATUS) + 1; k < (1 << ecp_pkg::OP_W); k++)
            queue_command(ecp_pkg::OP_W'(k), HANDLE_BASE, '0, 1'b0, 1'b0, '0,
                          ecp_pkg::MIN_LENGTH, 1'b1);
        queue_command(ecp_pkg::OP_CLOSE, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_CLOSE, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_CREATE, 0, '0, 1'b0, 1'b0, '0, '0, 1'b0);
        queue_command(ecp_pkg::OP_READ, HANDLE_BASE + 1, '0, 1'b0, 1'b0, '0,
                      ecp_pkg::MIN_LENGTH, 1'b1);
        command_queue.push_back(pause_word);

        // Random phases with different sender idling; each fills the pool past full
        // and then frees most of it.
        for (phase = 0; phase < 3; phase++)
        begin
            idle = (phase == 0) ? 0 : (phase == 1) ? 72 : 12;
            for (n = 0; n < 250; n++)
                command_queue.push_back(random_command(MIX_OPS, idle));
            for (n = 0; n < 90; n++)
                command_queue.push_back(random_command(FILL_POOL, idle));
            command_queue.push_back(pause_word);
            for (n = 0; n < 150; n++)
                command_queue.push_back(random_command(MIX_OPS, idle));
            for (n = 0; n < 80; n++)
                command_queue.push_back(random_command(EMPTY_POOL, idle));
            for (n = 0; n < 100; n++)
                command_queue.push_back(random_command(MIX_OPS, idle));
            command_queue.push_back(pause_word);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Let every word go out, then wait for the last results.
        while (command_queue.size() != 0 || start)
            @(posedge clk);
        for (n = 0; n < REPLY_WAIT && expected_replies.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch("result words never arrived",
                            ecp_pkg::CNT_W'(expected_replies.size()), '0);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/ecp_pkg.sv
rtl/ecp_counter_ram.sv
rtl/ecp_slot_alloc.sv
rtl/event_counter_pool.sv
sim/testbench.sv
